// ===== design/rkwpc_pkg.sv =====
// Package: payload structs, command codes and register constants for the watchdog power cycler.
package rkwpc_pkg;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_KICK  = 3'd3,
        CMD_SET   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_TIMEOUT_MS   = 2'd0,
        CFG_OFF_TIME_MS  = 2'd1,
        CFG_STAMP_WINDOW = 2'd2
    } t_cfg_index;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [31:0] TIMEOUT_MS_RESET   = 32'd600000;
    localparam logic [15:0] OFF_TIME_MS_RESET  = 16'd5000;
    localparam logic [7:0]  STAMP_WINDOW_RESET = 8'd5;
    localparam logic [3:0]  SWITCHES_ALL_ON    = 4'hF;
    localparam logic [3:0]  SWITCHES_ALL_OFF   = 4'h0;
    localparam logic [2:0]  SWITCH_INDEX_MIN   = 3'd1;
    localparam logic [2:0]  SWITCH_INDEX_MAX   = 3'd4;

    typedef struct packed {
        logic [2:0]        command;
        logic [31:0]       kick_stamp;
        logic [31:0]       current_seconds;
        logic [2:0]        switch_index;
        logic signed [7:0] switch_level;
    } t_in_item;

    typedef struct packed {
        logic [3:0] switch_lines;
        logic       timer_running;
        logic       expired;
        logic       cycling;
        logic       kick_accepted;
    } t_out_item;

endpackage

// ===== design/remote_kicked_watchdog_power_cycler.sv =====
// Top level: watchdog countdown with remote kick check and four power switch outputs.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one command per transfer:
//   a millisecond tick, start, stop, kick (with seconds stamp and wall time) or set switch.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly one result
//   per command: switch levels, running flag, expiry pulse, off-phase flag, kick verdict.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data) writes timeout_ms, off_time_ms and
//   stamp_window; write only while no command is in flight.
// Pipeline and throughput:
//   A transfer lands in the input register and is then processed (state update plus
//   result) into the output register, from which the result is transferred. One
//   command is taken every clock while o_in_stall is low; the state update is one
//   decrement or window compare per command.
// Reset (synchronous, active low):
//   Registers go to 600000 / 5000 / 5, countdown stopped, no off phase, all switches high.
// Stall:
//   When i_out_stall holds a pending result, the stage behind it freezes; o_in_stall
//   rises only when the input register is also occupied, so one result can wait while
//   the next command is already taken.
module remote_kicked_watchdog_power_cycler (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  rkwpc_pkg::t_in_item                      i_in_data,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output rkwpc_pkg::t_out_item                     o_out_data,
    input  logic                                     i_cfg_we,
    input  logic [rkwpc_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [rkwpc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    // Configuration registers
    logic [31:0] r_timeout_ms;
    logic [15:0] r_off_time_ms;
    logic [7:0]  r_stamp_window;

    // Watchdog state
    logic [31:0] r_countdown,  n_countdown;
    logic        r_running,    n_running;
    logic        r_in_cycle,   n_in_cycle;
    logic [15:0] r_off_count,  n_off_count;
    logic [3:0]  r_switches,   n_switches;

    // Pipeline registers
    logic                 r_s1_valid;
    rkwpc_pkg::t_in_item  r_s1;
    logic                 r_out_valid;
    rkwpc_pkg::t_out_item r_out, n_out;

    logic out_free;
    logic s1_fire;
    logic in_fire;

    // Kick window check
    logic [31:0] kick_diff;
    logic [31:0] kick_diff_inv;
    logic [8:0]  kick_neg_mag;
    logic        kick_in_window;

    // Switch decode
    logic [1:0]  sw_bit;
    logic        sw_index_ok;
    logic        sw_on;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms   <= rkwpc_pkg::TIMEOUT_MS_RESET;
            r_off_time_ms  <= rkwpc_pkg::OFF_TIME_MS_RESET;
            r_stamp_window <= rkwpc_pkg::STAMP_WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rkwpc_pkg::CFG_TIMEOUT_MS:   r_timeout_ms   <= i_cfg_data;
                rkwpc_pkg::CFG_OFF_TIME_MS:  r_off_time_ms  <= i_cfg_data[15:0];
                rkwpc_pkg::CFG_STAMP_WINDOW: r_stamp_window <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Kick accepted when |stamp - now| < window. Window is at most 255, so only
    // differences whose upper 24 bits are all zeros or all ones can pass.
    // A negative difference has magnitude ~diff + 1; the most negative value
    // never passes since its upper bits are not all zeros after inversion.
    assign kick_diff     = r_s1.kick_stamp - r_s1.current_seconds;
    assign kick_diff_inv = ~kick_diff;
    assign kick_neg_mag  = {1'b0, kick_diff_inv[7:0]} + 9'd1;

    always_comb begin
        if (!kick_diff[31]) begin
            kick_in_window = (kick_diff[31:8] == 24'd0) && (kick_diff[7:0] < r_stamp_window);
        end else begin
            kick_in_window = (kick_diff_inv[31:8] == 24'd0)
                          && (kick_neg_mag < {1'b0, r_stamp_window});
        end
    end

    assign sw_index_ok = (r_s1.switch_index >= rkwpc_pkg::SWITCH_INDEX_MIN)
                      && (r_s1.switch_index <= rkwpc_pkg::SWITCH_INDEX_MAX);
    assign sw_bit      = 2'(r_s1.switch_index - rkwpc_pkg::SWITCH_INDEX_MIN);
    assign sw_on       = (r_s1.switch_level > 8'sd0);

    // Process one command: update state and form the result
    always_comb begin
        n_countdown = r_countdown;
        n_running   = r_running;
        n_in_cycle  = r_in_cycle;
        n_off_count = r_off_count;
        n_switches  = r_switches;
        n_out       = '0;

        unique case (r_s1.command)
            rkwpc_pkg::CMD_TICK: begin
                if (r_in_cycle) begin
                    if (r_off_count <= 16'd1) begin
                        // Off phase over: power back on, restart countdown
                        n_off_count = 16'd0;
                        n_in_cycle  = 1'b0;
                        n_switches  = rkwpc_pkg::SWITCHES_ALL_ON;
                        n_countdown = r_timeout_ms;
                        n_running   = 1'b1;
                    end else begin
                        n_off_count = r_off_count - 16'd1;
                    end
                end else if (r_running) begin
                    if (r_countdown <= 32'd1) begin
                        // Expiry: drop all switches and enter off phase
                        n_countdown   = 32'd0;
                        n_running     = 1'b0;
                        n_in_cycle    = 1'b1;
                        n_off_count   = r_off_time_ms;
                        n_switches    = rkwpc_pkg::SWITCHES_ALL_OFF;
                        n_out.expired = 1'b1;
                    end else begin
                        n_countdown = r_countdown - 32'd1;
                    end
                end
            end
            rkwpc_pkg::CMD_START: begin
                if (!r_in_cycle) begin
                    n_countdown = r_timeout_ms;
                    n_running   = 1'b1;
                end
            end
            rkwpc_pkg::CMD_STOP: begin
                if (!r_in_cycle) begin
                    n_running = 1'b0;
                end
            end
            rkwpc_pkg::CMD_KICK: begin
                if (!r_in_cycle && kick_in_window) begin
                    n_countdown         = r_timeout_ms;
                    n_running           = 1'b1;
                    n_out.kick_accepted = 1'b1;
                end
            end
            rkwpc_pkg::CMD_SET: begin
                if (!r_in_cycle && sw_index_ok) begin
                    n_switches[sw_bit] = sw_on;
                end
            end
            default: ;  // undefined codes: no change
        endcase

        n_out.switch_lines  = n_switches;
        n_out.timer_running = n_running;
        n_out.cycling       = n_in_cycle;
    end

    // Control state and watchdog state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_countdown <= 32'd0;
            r_running   <= 1'b0;
            r_in_cycle  <= 1'b0;
            r_off_count <= 16'd0;
            r_switches  <= rkwpc_pkg::SWITCHES_ALL_ON;
        end else begin
            // Input register: take a new transfer whenever it empties or advances
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            // Output register: load on process, drop when taken
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_countdown <= n_countdown;
                r_running   <= n_running;
                r_in_cycle  <= n_in_cycle;
                r_off_count <= n_off_count;
                r_switches  <= n_switches;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in_data;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== design/rkwpc_checker.sv =====
// Checker: port-level assertions for the watchdog power cycler, bound to the top level.
module rkwpc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input rkwpc_pkg::t_out_item              o_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // Off phase keeps every switch low
    a_cycle_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.cycling |-> o_out_data.switch_lines == 4'h0)
        else $error("switch high during off phase");

    // Expiry enters the off phase with the countdown stopped
    a_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.expired |->
            o_out_data.cycling && !o_out_data.timer_running)
        else $error("expiry without off phase");

    // Accepted kick leaves the countdown running outside the off phase
    a_kick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kick_accepted |->
            o_out_data.timer_running && !o_out_data.cycling && !o_out_data.expired)
        else $error("accepted kick with wrong state");

    // Input stall only while a result is being held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output is free");

endmodule

bind remote_kicked_watchdog_power_cycler rkwpc_checker u_rkwpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
